/* hdl/inverse_square_attractor_step_core_assert.svh */
// Assertion macros for the attractor step core.
// Included by the top level only; no other dependencies.
`ifndef INVERSE_SQUARE_ATTRACTOR_STEP_CORE_ASSERT_SVH
`define INVERSE_SQUARE_ATTRACTOR_STEP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ISA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ISA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ISA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ISA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/isa_pkg.sv */
// Shared types, constants and saturation and magnitude helpers for the attractor step core.
// No dependencies.
`default_nettype none
package isa_pkg;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ATTR_RST_INT = 300;
  localparam int unsigned STRENGTH_RST_INT = 50;
  localparam int unsigned WIDTH_RST_INT = 800;
  localparam int unsigned HEIGHT_RST_INT = 600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTR_X   = 3'd0,
    CFG_ATTR_Y   = 3'd1,
    CFG_STRENGTH = 3'd2,
    CFG_BOUND_X  = 3'd3,
    CFG_BOUND_Y  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               remove;
  } out_t;

  typedef struct packed {
    logic valid;
    logic en;
  } pipe_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction
endpackage
`default_nettype wire

/* hdl/isa_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with side band.
// Uses isa_pkg for the pipeline control struct.
`default_nettype none
module isa_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire isa_pkg::pipe_ctl_t    ctl_i,
  input  wire logic [63:0]           rad_i,
  input  wire logic [SIDE_W-1:0]     side_i,
  output logic                       valid_o,
  output logic [31:0]                root_o,
  output logic [SIDE_W-1:0]          side_o
);
  logic [35:0]       rem_q  [32];
  logic [31:0]       root_q [32];
  logic [63:0]       rad_q  [32];
  logic [SIDE_W-1:0] side_q [32];
  logic              vld_q  [32];

  for (genvar k = 0; k < 32; k++) begin : g_st
    logic [35:0]       rem_c;
    logic [31:0]       root_c;
    logic [63:0]       rad_c;
    logic [SIDE_W-1:0] side_c;
    logic              vld_c;
    logic [35:0]       rem_sh;
    logic [35:0]       trial;
    logic              ge;

    if (k == 0) begin : g_in
      assign rem_c  = '0;
      assign root_c = '0;
      assign rad_c  = rad_i;
      assign side_c = side_i;
      assign vld_c  = ctl_i.valid;
    end else begin : g_prev
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
      assign rad_c  = rad_q[k-1];
      assign side_c = side_q[k-1];
      assign vld_c  = vld_q[k-1];
    end

    assign rem_sh = {rem_c[33:0], rad_c[63:62]};
    assign trial  = {2'b00, root_c, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_c[30:0], ge};
        rad_q[k]  <= {rad_c[61:0], 2'b00};
        side_q[k] <= side_c;
      end
    end
  end

  assign valid_o = vld_q[31];
  assign root_o  = root_q[31];
  assign side_o  = side_q[31];
endmodule
`default_nettype wire

/* hdl/isa_div.sv */
// Pipelined restoring divider, one quotient bit per stage, lanes share the divisor.
// Uses isa_pkg for the pipeline control struct.
`default_nettype none
module isa_div #(
  parameter int unsigned NUM_W  = 48,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned LANES  = 1,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire isa_pkg::pipe_ctl_t              ctl_i,
  input  wire logic [LANES-1:0][NUM_W-1:0]     num_i,
  input  wire logic [DEN_W-1:0]                den_i,
  input  wire logic [SIDE_W-1:0]               side_i,
  output logic                                 valid_o,
  output logic [LANES-1:0][NUM_W-1:0]          quo_o,
  output logic [DEN_W-1:0]                     den_o,
  output logic [SIDE_W-1:0]                    side_o
);
  logic [LANES-1:0][NUM_W-1:0] num_q  [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] rem_q  [NUM_W];
  logic [DEN_W-1:0]            den_q  [NUM_W];
  logic [SIDE_W-1:0]           side_q [NUM_W];
  logic                        vld_q  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_st
    logic [LANES-1:0][NUM_W-1:0] num_c;
    logic [LANES-1:0][DEN_W-1:0] rem_c;
    logic [DEN_W-1:0]            den_c;
    logic [SIDE_W-1:0]           side_c;
    logic                        vld_c;
    logic [LANES-1:0][NUM_W-1:0] num_d;
    logic [LANES-1:0][DEN_W-1:0] rem_d;

    if (k == 0) begin : g_in
      assign num_c  = num_i;
      assign rem_c  = '0;
      assign den_c  = den_i;
      assign side_c = side_i;
      assign vld_c  = ctl_i.valid;
    end else begin : g_prev
      assign num_c  = num_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign den_c  = den_q[k-1];
      assign side_c = side_q[k-1];
      assign vld_c  = vld_q[k-1];
    end

    always_comb begin
      logic [DEN_W:0] r;
      logic [DEN_W:0] diff;
      logic           ge;
      for (int l = 0; l < LANES; l++) begin
        r        = {rem_c[l], num_c[l][NUM_W-1]};
        ge       = (r >= {1'b0, den_c});
        diff     = r - {1'b0, den_c};
        rem_d[l] = ge ? diff[DEN_W-1:0] : r[DEN_W-1:0];
        num_d[l] = {num_c[l][NUM_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        num_q[k]  <= num_d;
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_c;
        side_q[k] <= side_c;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = num_q[NUM_W-1];
  assign den_o   = den_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];
endmodule
`default_nettype wire

/* hdl/inverse_square_attractor_step_core.sv */
// Top level: one semi-implicit Euler step toward a fixed attractor, fully pipelined.
// Depends on isa_pkg, isa_sqrt, isa_div and the assertion macro header.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid_i, stall_o, in_i        | sink
//  out     | out_valid_o, stall_i, out_o      | source
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i | sink
//
// One transaction per cycle while the pipeline is not frozen; the path runs through
// the 32-stage root and the two bit-per-stage dividers.
// Reset clears all valid bits and loads the register defaults.
// A stalled full output register freezes the whole pipeline.
`default_nettype none
`include "inverse_square_attractor_step_core_assert.svh"
module inverse_square_attractor_step_core #(
  parameter int unsigned FRAC_BITS = isa_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 stall_o,
  input  wire isa_pkg::in_t                    in_i,
  output logic                                 out_valid_o,
  input  wire logic                            stall_i,
  output isa_pkg::out_t                        out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [isa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [isa_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned NUM1_W = 32 + F;
  localparam int unsigned NUM2_W = 32 + 2 * F;
  localparam logic [63:0] THRESH_W = ((64'd1 << F) + 64'd5) / 64'd10;
  localparam logic [31:0] THRESH   = THRESH_W[31:0];
  localparam logic [63:0] S32_MAX  = 64'h7fff_ffff;
  localparam logic [63:0] ATTR_RAW = 64'(isa_pkg::ATTR_RST_INT) << F;
  localparam logic [63:0] K_RAW    = 64'(isa_pkg::STRENGTH_RST_INT) << F;
  localparam logic [63:0] BX_RAW   = 64'(isa_pkg::WIDTH_RST_INT) << F;
  localparam logic [63:0] BY_RAW   = 64'(isa_pkg::HEIGHT_RST_INT) << F;
  localparam logic [31:0] ATTR_RST = (ATTR_RAW > S32_MAX) ? S32_MAX[31:0] : ATTR_RAW[31:0];
  localparam logic [31:0] K_RST    = (K_RAW > S32_MAX) ? S32_MAX[31:0] : K_RAW[31:0];
  localparam logic [30:0] BX_RST   = (BX_RAW > S32_MAX) ? S32_MAX[30:0] : BX_RAW[30:0];
  localparam logic [30:0] BY_RST   = (BY_RAW > S32_MAX) ? S32_MAX[30:0] : BY_RAW[30:0];

  typedef struct packed {
    isa_pkg::in_t       in;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } sq_side_t;

  typedef struct packed {
    isa_pkg::in_t in;
    logic         dx_neg;
    logic         dy_neg;
    logic         k_neg;
    logic         near_n;
  } dv_side_t;

  typedef struct packed {
    dv_side_t   s;
    logic [F:0] ux;
    logic [F:0] uy;
  } d2_side_t;

  // configuration
  logic signed [31:0] attr_x_q, attr_y_q, strength_q;
  logic [30:0]        bound_x_q, bound_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_x_q   <= ATTR_RST;
      attr_y_q   <= ATTR_RST;
      strength_q <= K_RST;
      bound_x_q  <= BX_RST;
      bound_y_q  <= BY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        isa_pkg::CFG_ATTR_X:   attr_x_q   <= cfg_wdata_i;
        isa_pkg::CFG_ATTR_Y:   attr_y_q   <= cfg_wdata_i;
        isa_pkg::CFG_STRENGTH: strength_q <= cfg_wdata_i;
        isa_pkg::CFG_BOUND_X:  bound_x_q  <= cfg_wdata_i[30:0];
        isa_pkg::CFG_BOUND_Y:  bound_y_q  <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  isa_pkg::out_t out_q;

  assign en      = !out_valid_q || !stall_i;
  assign stall_o = !en;

  // S0: offsets
  logic               s0_valid_q;
  isa_pkg::in_t       s0_in_q;
  logic signed [31:0] s0_dx_q, s0_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_in_q <= in_i;
      s0_dx_q <= isa_pkg::sat32(34'(attr_x_q) - 34'(in_i.pos_x));
      s0_dy_q <= isa_pkg::sat32(34'(attr_y_q) - 34'(in_i.pos_y));
    end
  end

  // S1: squares
  logic               s1_valid_q;
  isa_pkg::in_t       s1_in_q;
  logic signed [31:0] s1_dx_q, s1_dy_q;
  logic [63:0]        s1_sqx_q, s1_sqy_q;
  logic [31:0]        s0_mx, s0_my;

  assign s0_mx = isa_pkg::mag32(s0_dx_q);
  assign s0_my = isa_pkg::mag32(s0_dy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_in_q  <= s0_in_q;
      s1_dx_q  <= s0_dx_q;
      s1_dy_q  <= s0_dy_q;
      s1_sqx_q <= 64'(s0_mx) * 64'(s0_mx);
      s1_sqy_q <= 64'(s0_my) * 64'(s0_my);
    end
  end

  // S2: squared distance
  logic        s2_valid_q;
  sq_side_t    s2_side_q;
  logic [63:0] s2_d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= '{in: s1_in_q, dx: s1_dx_q, dy: s1_dy_q};
      s2_d2_q   <= s1_sqx_q + s1_sqy_q;
    end
  end

  // distance
  logic        sq_valid;
  logic [31:0] sq_d;
  sq_side_t    sq_side;

  isa_sqrt #(
    .SIDE_W ($bits(sq_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{valid: s2_valid_q, en: en}),
    .rad_i   (s2_d2_q),
    .side_i  (s2_side_q),
    .valid_o (sq_valid),
    .root_o  (sq_d),
    .side_o  (sq_side)
  );

  // K/d, dx/d, dy/d
  logic [2:0][NUM1_W-1:0] dv1_num, dv1_quo;
  dv_side_t               dv1_side_in, dv1_side;
  logic                   dv1_valid;
  logic [31:0]            dv1_d;

  assign dv1_num[0] = {isa_pkg::mag32(strength_q), F'(0)};
  assign dv1_num[1] = {isa_pkg::mag32(sq_side.dx), F'(0)};
  assign dv1_num[2] = {isa_pkg::mag32(sq_side.dy), F'(0)};
  assign dv1_side_in = '{in: sq_side.in, dx_neg: sq_side.dx[31], dy_neg: sq_side.dy[31],
                         k_neg: strength_q[31], near_n: (sq_d > THRESH)};

  isa_div #(
    .NUM_W  (NUM1_W),
    .DEN_W  (32),
    .LANES  (3),
    .SIDE_W ($bits(dv_side_t))
  ) u_div_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{valid: sq_valid, en: en}),
    .num_i   (dv1_num),
    .den_i   (sq_d),
    .side_i  (dv1_side_in),
    .valid_o (dv1_valid),
    .quo_o   (dv1_quo),
    .den_o   (dv1_d),
    .side_o  (dv1_side)
  );

  // (K/d << F) / d
  logic [0:0][NUM2_W-1:0] dv2_num, dv2_quo;
  d2_side_t               dv2_side_in, dv2_side;
  logic                   dv2_valid;
  logic [31:0]            dv2_d;

  assign dv2_num[0]  = {dv1_quo[0], F'(0)};
  assign dv2_side_in = '{s: dv1_side, ux: dv1_quo[1][F:0], uy: dv1_quo[2][F:0]};

  isa_div #(
    .NUM_W  (NUM2_W),
    .DEN_W  (32),
    .LANES  (1),
    .SIDE_W ($bits(d2_side_t))
  ) u_div_force (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{valid: dv1_valid, en: en}),
    .num_i   (dv2_num),
    .den_i   (dv1_d),
    .side_i  (dv2_side_in),
    .valid_o (dv2_valid),
    .quo_o   (dv2_quo),
    .den_o   (dv2_d),
    .side_o  (dv2_side)
  );

  // F: force magnitude, clamped to the signed range
  logic        f_valid_q;
  d2_side_t    f_side_q;
  logic [31:0] f_mag_q;
  logic        f_neg_q;
  logic        fm_big;
  logic [31:0] fm_mag;

  assign fm_big = |dv2_quo[0][NUM2_W-1:31];
  assign fm_mag = fm_big ? (dv2_side.s.k_neg ? 32'h8000_0000 : 32'h7fff_ffff)
                         : dv2_quo[0][31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= dv2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_side_q <= dv2_side;
      f_mag_q  <= fm_mag;
      f_neg_q  <= dv2_side.s.k_neg && (|dv2_quo[0]) && (dv2_d != 32'd0 || 1'b1);
    end
  end

  // P: force times direction
  logic           p_valid_q;
  dv_side_t       p_side_q;
  logic           p_neg_q;
  logic [31:0]    p_ax_q, p_ay_q;
  logic [F+32:0]  prod_x, prod_y;

  assign prod_x = (F+33)'(f_mag_q) * (F+33)'(f_side_q.ux);
  assign prod_y = (F+33)'(f_mag_q) * (F+33)'(f_side_q.uy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_side_q <= f_side_q.s;
      p_neg_q  <= f_neg_q;
      p_ax_q   <= prod_x[F+31:F];
      p_ay_q   <= prod_y[F+31:F];
    end
  end

  // A: velocity update
  logic               a_valid_q;
  isa_pkg::in_t       a_in_q;
  logic signed [31:0] a_vx_q, a_vy_q;
  logic signed [33:0] acc_x, acc_y;

  assign acc_x = (p_neg_q != p_side_q.dx_neg) ? -34'({2'b00, p_ax_q}) : 34'({2'b00, p_ax_q});
  assign acc_y = (p_neg_q != p_side_q.dy_neg) ? -34'({2'b00, p_ay_q}) : 34'({2'b00, p_ay_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_in_q <= p_side_q.in;
      a_vx_q <= p_side_q.near_n ? isa_pkg::sat32(34'(p_side_q.in.vel_x) + acc_x)
                                : p_side_q.in.vel_x;
      a_vy_q <= p_side_q.near_n ? isa_pkg::sat32(34'(p_side_q.in.vel_y) + acc_y)
                                : p_side_q.in.vel_y;
    end
  end

  // B: position update
  logic               b_valid_q;
  logic signed [31:0] b_px_q, b_py_q, b_vx_q, b_vy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_px_q <= isa_pkg::sat32(34'(a_in_q.pos_x) + 34'(a_vx_q));
      b_py_q <= isa_pkg::sat32(34'(a_in_q.pos_y) + 34'(a_vy_q));
      b_vx_q <= a_vx_q;
      b_vy_q <= a_vy_q;
    end
  end

  // output register with window check
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.new_pos_x <= b_px_q;
      out_q.new_pos_y <= b_py_q;
      out_q.new_vel_x <= b_vx_q;
      out_q.new_vel_y <= b_vy_q;
      out_q.remove    <= b_px_q[31] || (b_px_q[30:0] > bound_x_q) ||
                         b_py_q[31] || (b_py_q[30:0] > bound_y_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `ISA_ASSERT_NOW(a_force_clamp, clk_i, rst_ni, f_valid_q,
                  f_neg_q || (f_mag_q != 32'h8000_0000))
  `ISA_ASSERT_NOW(a_unit_range, clk_i, rst_ni, f_valid_q && f_side_q.s.near_n,
                  !f_side_q.ux[F] || (f_side_q.ux[F-1:0] == '0))
  `ISA_ASSERT_NEXT(a_near_hold, clk_i, rst_ni, en && p_valid_q && !p_side_q.near_n,
                   a_vx_q == $past(p_side_q.in.vel_x))
endmodule
`default_nettype wire
